### rtl/spbs_pkg.sv
package spbs_pkg;

   // request commands
   localparam logic CMD_READ  = 1'b0;
   localparam logic CMD_WRITE = 1'b1;

   localparam logic [7:0] BYTE_ZERO = 8'h00;

   // width of the pages_in_use result field
   localparam int INUSE_OUT_W = 5;

   // operation on the slot table in one cycle
   typedef struct packed {
      logic rd;       // registered read of tag, count and valid at idx
      logic alloc;    // claim a vacant slot: tag, count of one, valid
      logic update;   // rewrite the count; a count of zero frees the slot
   } slot_op_type;

   // outcome of comparing the last read entry against the request page
   typedef struct packed {
      logic hit;      // valid slot holding the request page
      logic vacant;   // slot is free
   } slot_stat_type;

   // operation on the byte store in one cycle
   typedef struct packed {
      logic re;
      logic we;
   } ram_op_type;

endpackage

### rtl/sparse_paged_byte_store_top.sv
// Sparse paged byte store.
// A byte memory over a 32-bit address space that keeps storage only for pages
// holding nonzero bytes. A request (req_cmd, req_byte_address, req_write_byte)
// reads or writes one byte; each request yields exactly one response carrying
// the byte read, a dropped-write flag and the number of resident pages.
// Channels use valid/ready; a request is taken only while the block is idle.
// The sequence: an accept step, then a look and a test state per slot scanned
// by the shared tag comparator (the scan stops at a hit), then a fetch and a
// modify state for the byte read/modify on a hit or an alloc state for an
// allocation, then a reply state that loads the response register.
// One request is in flight.
// The response register decouples the sides: the next request is accepted
// while a response waits, and the block then holds in its reply step until
// rsp_ready frees the register.
// After reset the byte store is zeroed while req_ready is held low;
// all slots start free.
module sparse_paged_byte_store_top #(
   parameter int PAGE_SLOTS       = 16,
   parameter int PAGE_OFFSET_BITS = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_cmd,
   input  logic [31:0] req_byte_address,
   input  logic [7:0]  req_write_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_read_byte,
   output logic        rsp_write_dropped,
   output logic [4:0]  rsp_pages_in_use
);

   localparam int SLOT_W  = (PAGE_SLOTS > 1) ? $clog2(PAGE_SLOTS) : 1;
   localparam int OFF_W   = PAGE_OFFSET_BITS;
   localparam int TAG_W   = 32 - OFF_W;
   localparam int CNT_W   = OFF_W + 1;
   localparam int INUSE_W = $clog2(PAGE_SLOTS + 1);
   localparam int DEPTH   = PAGE_SLOTS << OFF_W;
   localparam int ADDR_W  = $clog2(DEPTH);
   localparam int OUT_W   = spbs_pkg::INUSE_OUT_W;

   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(PAGE_SLOTS - 1);

   // sequencer states
   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_LOOK   = 3'd1;
   localparam logic [2:0] S_TEST   = 3'd2;
   localparam logic [2:0] S_FETCH  = 3'd3;
   localparam logic [2:0] S_MODIFY = 3'd4;
   localparam logic [2:0] S_ALLOC  = 3'd5;
   localparam logic [2:0] S_REPLY  = 3'd6;

   logic [2:0]         state_ff, state_in;
   logic               cmd_ff, cmd_in;
   logic [TAG_W-1:0]   page_ff, page_in;
   logic [OFF_W-1:0]   off_ff, off_in;
   logic [7:0]         wb_ff, wb_in;
   logic [SLOT_W-1:0]  scan_ff, scan_in;
   logic [SLOT_W-1:0]  slot_ff, slot_in;
   logic               free_found_ff, free_found_in;
   logic [SLOT_W-1:0]  free_slot_ff, free_slot_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [7:0]         rd_byte_ff, rd_byte_in;
   logic               dropped_ff, dropped_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [7:0]         rsp_byte_ff, rsp_byte_in;
   logic               rsp_drop_ff, rsp_drop_in;
   logic [OUT_W-1:0]   rsp_inuse_ff, rsp_inuse_in;

   spbs_pkg::slot_op_type   slot_op;
   spbs_pkg::slot_stat_type slot_stat;
   spbs_pkg::ram_op_type    ram_op;
   logic [SLOT_W-1:0]  slot_idx;
   logic [CNT_W-1:0]   tbl_cnt;
   logic [CNT_W-1:0]   cnt_next;
   logic [INUSE_W-1:0] inuse;
   logic [INUSE_W+OUT_W-1:0] inuse_ext;
   logic [ADDR_W-1:0]  ram_addr;
   logic [7:0]         ram_rdata;
   logic               ram_busy;
   logic               req_take;
   logic               rsp_free;
   logic               old_zero;
   logic               new_zero;

   assign req_ready = (state_ff == S_IDLE) && !ram_busy;
   assign req_take  = req_valid && req_ready;
   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign inuse_ext = (INUSE_W + OUT_W)'(inuse);

   // nonzero count after replacing the addressed byte
   assign old_zero = (ram_rdata == spbs_pkg::BYTE_ZERO);
   assign new_zero = (wb_ff == spbs_pkg::BYTE_ZERO);
   always_comb begin
      cnt_next = cnt_ff;
      if (old_zero && !new_zero) begin
         cnt_next = cnt_ff + CNT_W'(1);
      end else if (!old_zero && new_zero && cnt_ff != '0) begin
         cnt_next = cnt_ff - CNT_W'(1);
      end
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      page_in       = page_ff;
      off_in        = off_ff;
      wb_in         = wb_ff;
      scan_in       = scan_ff;
      slot_in       = slot_ff;
      free_found_in = free_found_ff;
      free_slot_in  = free_slot_ff;
      cnt_in        = cnt_ff;
      rd_byte_in    = rd_byte_ff;
      dropped_in    = dropped_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_byte_in   = rsp_byte_ff;
      rsp_drop_in   = rsp_drop_ff;
      rsp_inuse_in  = rsp_inuse_ff;
      slot_op       = '0;
      ram_op        = '0;
      slot_idx      = slot_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               cmd_in        = req_cmd;
               page_in       = req_byte_address[31:OFF_W];
               off_in        = req_byte_address[OFF_W-1:0];
               wb_in         = req_write_byte;
               scan_in       = '0;
               free_found_in = 1'b0;
               rd_byte_in    = spbs_pkg::BYTE_ZERO;
               dropped_in    = 1'b0;
               state_in      = S_LOOK;
            end
         end
         S_LOOK: begin
            slot_idx   = scan_ff;
            slot_op.rd = 1'b1;
            state_in   = S_TEST;
         end
         S_TEST: begin
            if (slot_stat.hit) begin
               slot_in  = scan_ff;
               cnt_in   = tbl_cnt;
               state_in = S_FETCH;
            end else begin
               if (slot_stat.vacant && !free_found_ff) begin
                  free_found_in = 1'b1;
                  free_slot_in  = scan_ff;
               end
               if (scan_ff != LAST_SLOT) begin
                  scan_in  = scan_ff + SLOT_W'(1);
                  state_in = S_LOOK;
               end else if (cmd_ff == spbs_pkg::CMD_WRITE && wb_ff != spbs_pkg::BYTE_ZERO) begin
                  if (free_found_ff) begin
                     slot_in  = free_slot_ff;
                     state_in = S_ALLOC;
                  end else if (slot_stat.vacant) begin
                     slot_in  = scan_ff;
                     state_in = S_ALLOC;
                  end else begin
                     dropped_in = 1'b1;
                     state_in   = S_REPLY;
                  end
               end else begin
                  state_in = S_REPLY;
               end
            end
         end
         S_FETCH: begin
            ram_op.re = 1'b1;
            state_in  = S_MODIFY;
         end
         S_MODIFY: begin
            if (cmd_ff == spbs_pkg::CMD_READ) begin
               rd_byte_in = ram_rdata;
            end else begin
               ram_op.we      = 1'b1;
               slot_op.update = 1'b1;
            end
            state_in = S_REPLY;
         end
         S_ALLOC: begin
            ram_op.we     = 1'b1;
            slot_op.alloc = 1'b1;
            state_in      = S_REPLY;
         end
         S_REPLY: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_byte_in  = rd_byte_ff;
               rsp_drop_in  = dropped_ff;
               rsp_inuse_in = inuse_ext[OUT_W-1:0];
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign ram_addr = ADDR_W'({slot_ff, off_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      page_ff       <= page_in;
      off_ff        <= off_in;
      wb_ff         <= wb_in;
      scan_ff       <= scan_in;
      slot_ff       <= slot_in;
      free_found_ff <= free_found_in;
      free_slot_ff  <= free_slot_in;
      cnt_ff        <= cnt_in;
      rd_byte_ff    <= rd_byte_in;
      dropped_ff    <= dropped_in;
      rsp_byte_ff   <= rsp_byte_in;
      rsp_drop_ff   <= rsp_drop_in;
      rsp_inuse_ff  <= rsp_inuse_in;
   end

   spbs_slot_table #(
      .PAGE_SLOTS (PAGE_SLOTS),
      .SLOT_W     (SLOT_W),
      .TAG_W      (TAG_W),
      .CNT_W      (CNT_W),
      .INUSE_W    (INUSE_W)
   ) u_slot_table (
      .clock  (clock),
      .reset  (reset),
      .op     (slot_op),
      .idx    (slot_idx),
      .tag_in (page_ff),
      .cnt_in (cnt_next),
      .stat   (slot_stat),
      .rd_cnt (tbl_cnt),
      .inuse  (inuse)
   );

   spbs_byte_ram #(
      .DEPTH  (DEPTH),
      .ADDR_W (ADDR_W)
   ) u_byte_ram (
      .clock (clock),
      .reset (reset),
      .op    (ram_op),
      .addr  (ram_addr),
      .wdata (wb_ff),
      .rdata (ram_rdata),
      .busy  (ram_busy)
   );

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_read_byte     = rsp_byte_ff;
   assign rsp_write_dropped = rsp_drop_ff;
   assign rsp_pages_in_use  = rsp_inuse_ff;

   // a dropped write only happens with every slot occupied
   a_drop_when_full: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_REPLY && dropped_ff) |-> inuse == INUSE_W'(PAGE_SLOTS))
      else $error("write dropped while a slot was free");

endmodule

### rtl/spbs_slot_table.sv
module spbs_slot_table #(
   parameter int PAGE_SLOTS = 16,
   parameter int SLOT_W     = 4,
   parameter int TAG_W      = 24,
   parameter int CNT_W      = 9,
   parameter int INUSE_W    = 5
) (
   input  logic                 clock,
   input  logic                 reset,
   input  spbs_pkg::slot_op_type op,
   input  logic [SLOT_W-1:0]    idx,
   input  logic [TAG_W-1:0]     tag_in,
   input  logic [CNT_W-1:0]     cnt_in,
   output spbs_pkg::slot_stat_type stat,
   output logic [CNT_W-1:0]     rd_cnt,
   output logic [INUSE_W-1:0]   inuse
);

   localparam int ENT_W = TAG_W + CNT_W;

   // tag and nonzero count per slot
   logic [ENT_W-1:0]      ent_mem [PAGE_SLOTS];
   logic [ENT_W-1:0]      ent_ff;
   logic                  vld_rd_ff;
   logic [PAGE_SLOTS-1:0] valid_ff;
   logic [PAGE_SLOTS-1:0] valid_in;
   logic [INUSE_W-1:0]    inuse_ff;
   logic [INUSE_W-1:0]    inuse_in;

   // entry memory: one write, one registered read
   always_ff @(posedge clock) begin
      if (op.alloc) begin
         ent_mem[idx] <= {tag_in, CNT_W'(1)};
      end else if (op.update) begin
         ent_mem[idx] <= {tag_in, cnt_in};
      end
      if (op.rd) begin
         ent_ff    <= ent_mem[idx];
         vld_rd_ff <= valid_ff[idx];
      end
   end

   // valid bits and resident page count
   always_comb begin
      valid_in = valid_ff;
      inuse_in = inuse_ff;
      if (op.alloc) begin
         valid_in[idx] = 1'b1;
         inuse_in      = inuse_ff + INUSE_W'(1);
      end else if (op.update && cnt_in == '0 && valid_ff[idx]) begin
         valid_in[idx] = 1'b0;
         inuse_in      = inuse_ff - INUSE_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         inuse_ff <= '0;
      end else begin
         valid_ff <= valid_in;
         inuse_ff <= inuse_in;
      end
   end

   // shared tag comparator
   assign stat.hit    = vld_rd_ff && (ent_ff[ENT_W-1:CNT_W] == tag_in);
   assign stat.vacant = !vld_rd_ff;
   assign rd_cnt      = ent_ff[CNT_W-1:0];
   assign inuse       = inuse_ff;

   a_inuse_matches_valid: assert property (@(posedge clock) disable iff (reset)
      inuse_ff == INUSE_W'($countones(valid_ff)))
      else $error("resident count out of step with valid bits");

   a_alloc_vacant: assert property (@(posedge clock) disable iff (reset)
      op.alloc |-> !valid_ff[idx])
      else $error("allocation into an occupied slot");

   a_update_resident: assert property (@(posedge clock) disable iff (reset)
      op.update |-> valid_ff[idx])
      else $error("count update on a free slot");

   a_inuse_bound: assert property (@(posedge clock) disable iff (reset)
      inuse_ff <= INUSE_W'(PAGE_SLOTS))
      else $error("more pages resident than slots");

endmodule

### rtl/spbs_byte_ram.sv
module spbs_byte_ram #(
   parameter int DEPTH  = 4096,
   parameter int ADDR_W = 12
) (
   input  logic                clock,
   input  logic                reset,
   input  spbs_pkg::ram_op_type op,
   input  logic [ADDR_W-1:0]   addr,
   input  logic [7:0]          wdata,
   output logic [7:0]          rdata,
   output logic                busy
);

   logic [7:0]        mem [DEPTH];
   logic [7:0]        rdata_ff;
   logic              clr_active_ff;
   logic              clr_active_in;
   logic [ADDR_W-1:0] clr_addr_ff;
   logic [ADDR_W-1:0] clr_addr_in;

   // zeroing sweep after reset, one byte per cycle
   always_comb begin
      clr_active_in = clr_active_ff;
      clr_addr_in   = clr_addr_ff;
      if (clr_active_ff) begin
         clr_addr_in = clr_addr_ff + ADDR_W'(1);
         if (clr_addr_ff == ADDR_W'(DEPTH - 1)) begin
            clr_active_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_active_ff <= 1'b1;
         clr_addr_ff   <= '0;
      end else begin
         clr_active_ff <= clr_active_in;
         clr_addr_ff   <= clr_addr_in;
      end
   end

   // single port byte array
   always_ff @(posedge clock) begin
      if (clr_active_ff) begin
         mem[clr_addr_ff] <= spbs_pkg::BYTE_ZERO;
      end else if (op.we) begin
         mem[addr] <= wdata;
      end
      if (op.re) begin
         rdata_ff <= mem[addr];
      end
   end

   assign rdata = rdata_ff;
   assign busy  = clr_active_ff;

   a_no_access_in_clear: assert property (@(posedge clock) disable iff (reset)
      clr_active_ff |-> !(op.we || op.re))
      else $error("byte store accessed during zeroing sweep");

endmodule
